@@ hdl/pket_pkg.sv @@
// ----------------------------------------------------------------------------
// pket_pkg
// Types and constants shared by the position keyed exit table.
// ----------------------------------------------------------------------------
package pket_pkg;

	localparam int COORD_BITS = 12;
	localparam int EXIT_BITS  = 16;

	localparam logic [1:0] ACT_ADD    = 2'd0;
	localparam logic [1:0] ACT_DELETE = 2'd1;
	localparam logic [1:0] ACT_LOOKUP = 2'd2;

	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef struct packed {
		logic [1:0]            action;
		logic [COORD_BITS-1:0] pos_x;
		logic [COORD_BITS-1:0] pos_y;
		logic [EXIT_BITS-1:0]  exit_in;
	} req_item_t;

	typedef struct packed {
		logic                 found;
		logic [EXIT_BITS-1:0] exit_out;
		logic                 status;
	} rsp_item_t;

	typedef struct packed {
		logic                  valid;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [EXIT_BITS-1:0]  exit_idx;
	} entry_t;

endpackage

@@ hdl/pket_store.sv @@
// ----------------------------------------------------------------------------
// pket_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pket_store #(
	parameter int DEPTH = 64
) (
	input  logic                           clk,
	input  logic                           wr_en,
	input  logic [$clog2(DEPTH)-1:0]       wr_addr,
	input  pket_pkg::entry_t               wr_data,
	input  logic [$clog2(DEPTH)-1:0]       rd_addr,
	output pket_pkg::entry_t               rd_data
);
	import pket_pkg::*;

	entry_t mem [DEPTH];
	entry_t rd_data_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_s1 <= mem[rd_addr];
	end

	assign rd_data = rd_data_s1;

endmodule

@@ hdl/position_keyed_exit_table.sv @@
// ----------------------------------------------------------------------------
// position_keyed_exit_table
// Associative table of exit indexes keyed by cell position (x, y).
//
// A request item carries an action (add or update, delete, lookup), a key
// position and an exit index. Each request gives exactly one response item:
// found (key was present before the action), exit_out (stored index on a
// lookup hit, else 0) and status (add dropped because the table is full).
// Both channels use valid/ready; one request is in work at a time.
// Every request scans all TABLE_DEPTH entries of the entry memory, one read
// per cycle through its single read port; the response is registered after
// the scan, a wait state and the commit state, and no new request is taken
// before then. A delete clears matching entries during the scan; an add
// writes its entry in the final cycle.
// After reset a clearing pass over the whole memory marks every entry free;
// req_ready stays low meanwhile. The response sits in an output register: a
// stalled receiver holds the block in its final cycle, while the next request
// may already be taken once the previous one has reached that register.
// ----------------------------------------------------------------------------
module position_keyed_exit_table #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  pket_pkg::req_item_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output pket_pkg::rsp_item_t rsp
);
	import pket_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

	typedef enum logic [4:0] {
		ST_CLEAR  = 5'b00001,
		ST_IDLE   = 5'b00010,
		ST_SCAN   = 5'b00100,
		ST_WAIT   = 5'b01000,
		ST_COMMIT = 5'b10000
	} state_t;

	state_t             state_q;
	logic [IDX_W-1:0]   idx_q;
	req_item_t          req_q;
	logic               rd_vld_s1;
	logic [IDX_W-1:0]   rd_idx_s1;
	logic               hit_q;
	logic [IDX_W-1:0]   hit_idx_q;
	logic [EXIT_BITS-1:0] hit_exit_q;
	logic               free_q;
	logic [IDX_W-1:0]   free_idx_q;
	logic               rsp_valid_q;
	rsp_item_t          rsp_q;

	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	entry_t             wr_data;
	entry_t             rd_data;
	logic               match;
	logic               req_fire;
	logic               commit_fire;
	rsp_item_t          result;

	pket_store #(
		.DEPTH(TABLE_DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(idx_q),
		.rd_data(rd_data)
	);

	assign req_ready   = (state_q == ST_IDLE);
	assign req_fire    = req_valid && req_ready;
	assign commit_fire = (state_q == ST_COMMIT) && (!rsp_valid_q || rsp_ready);
	assign match       = rd_vld_s1 && rd_data.valid &&
	                     (rd_data.x == req_q.pos_x) && (rd_data.y == req_q.pos_y);

	always_comb begin
		result = '0;
		case (req_q.action)
			ACT_ADD: begin
				result.found  = hit_q;
				result.status = (!hit_q && !free_q) ? STATUS_FULL : STATUS_DONE;
			end
			ACT_DELETE: begin
				result.found = hit_q;
			end
			ACT_LOOKUP: begin
				result.found    = hit_q;
				result.exit_out = hit_q ? hit_exit_q : '0;
			end
			default: begin
				result = '0;
			end
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = rd_idx_s1;
		wr_data = '0;
		if (state_q == ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = idx_q;
		end else if (match && (req_q.action == ACT_DELETE)) begin
			wr_en   = 1'b1;
			wr_addr = rd_idx_s1;
		end else if (commit_fire && (req_q.action == ACT_ADD) && (hit_q || free_q)) begin
			wr_en            = 1'b1;
			wr_addr          = hit_q ? hit_idx_q : free_idx_q;
			wr_data.valid    = 1'b1;
			wr_data.x        = req_q.pos_x;
			wr_data.y        = req_q.pos_y;
			wr_data.exit_idx = req_q.exit_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
			hit_q     <= 1'b0;
			free_q    <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN);
			case (state_q)
				ST_CLEAR: begin
					idx_q <= idx_q + IDX_W'(1);
					if (idx_q == LAST_IDX) begin
						idx_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_fire) begin
						idx_q   <= '0;
						hit_q   <= 1'b0;
						free_q  <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					idx_q <= idx_q + IDX_W'(1);
					if (idx_q == LAST_IDX) begin
						idx_q   <= '0;
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (commit_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (match && !hit_q) begin
				hit_q <= 1'b1;
			end
			if (rd_vld_s1 && !rd_data.valid && !free_q) begin
				free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q;
		if (req_fire) begin
			req_q <= req;
		end
		if (match && !hit_q) begin
			hit_idx_q  <= rd_idx_s1;
			hit_exit_q <= rd_data.exit_idx;
		end
		if (rd_vld_s1 && !rd_data.valid && !free_q) begin
			free_idx_q <= rd_idx_s1;
		end
		if (commit_fire) begin
			rsp_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (commit_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ hdl/pket_checker.sv @@
// ----------------------------------------------------------------------------
// pket_checker
// Port-level checks of the position keyed exit table, bound to the top level.
// ----------------------------------------------------------------------------
module pket_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input pket_pkg::rsp_item_t rsp
);
	import pket_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response item changed while stalled");

	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in work");

	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == STATUS_FULL) |-> !rsp.found && (rsp.exit_out == '0))
		else $error("full response carries a hit");

	a_exit_needs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.exit_out != '0) |-> rsp.found)
		else $error("exit index without a hit");

endmodule

bind position_keyed_exit_table pket_checker u_pket_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_ready(req_ready),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp      (rsp)
);

@@ sim/pket_exit_table_checker.sv @@
// ----------------------------------------------------------------------------
// pket_exit_table_checker
// Watches both channels of the position keyed exit table. Every request
// item taken is run through a local copy of the table to predict its
// response item. Every response item taken is compared, field by field,
// with the oldest prediction. Error and progress counts go to the bench top.
// ----------------------------------------------------------------------------
module pket_exit_table_checker #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_ready,
	input  pket_pkg::req_item_t req,
	input  logic                rsp_valid,
	input  logic                rsp_ready,
	input  pket_pkg::rsp_item_t rsp,
	output int                  errors,
	output int                  pending,
	output int                  responses,
	output int                  full_drops,
	output int                  key_hits
);

	import pket_pkg::*;

	entry_t    slot_table [TABLE_DEPTH];
	rsp_item_t expected_rsp [$];
	int        n_err;
	int        n_rsp;
	int        n_full;
	int        n_hit;

	function automatic rsp_item_t predict_exit_table(input req_item_t it);
		rsp_item_t r;
		int        hit;
		int        free_slot;
		r         = '0;
		hit       = -1;
		free_slot = -1;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (slot_table[i].valid && slot_table[i].x == it.pos_x &&
			    slot_table[i].y == it.pos_y && hit < 0)
				hit = i;
			if (!slot_table[i].valid && free_slot < 0)
				free_slot = i;
		end
		case (it.action)
			ACT_ADD: begin
				if (hit >= 0) begin
					slot_table[hit].exit_idx = it.exit_in;
					r.found = 1'b1;
				end else if (free_slot >= 0) begin
					slot_table[free_slot].valid    = 1'b1;
					slot_table[free_slot].x        = it.pos_x;
					slot_table[free_slot].y        = it.pos_y;
					slot_table[free_slot].exit_idx = it.exit_in;
				end else begin
					r.status = STATUS_FULL;
				end
			end
			ACT_DELETE: begin
				for (int i = 0; i < TABLE_DEPTH; i++) begin
					if (slot_table[i].valid && slot_table[i].x == it.pos_x &&
					    slot_table[i].y == it.pos_y)
						slot_table[i].valid = 1'b0;
				end
				r.found = (hit >= 0);
			end
			ACT_LOOKUP: begin
				if (hit >= 0) begin
					r.found    = 1'b1;
					r.exit_out = slot_table[hit].exit_idx;
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	always @(posedge clk) begin : watch
		rsp_item_t want;
		if (!arst_n) begin
			foreach (slot_table[i])
				slot_table[i] = '0;
			expected_rsp.delete();
			n_err  = 0;
			n_rsp  = 0;
			n_full = 0;
			n_hit  = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				n_rsp++;
				if (expected_rsp.size() == 0) begin
					if (n_err < 10)
						$display("unexpected response: found=%0b exit_out=%h status=%0b",
							rsp.found, rsp.exit_out, rsp.status);
					n_err++;
				end else begin
					want = expected_rsp.pop_front();
					if (rsp.found !== want.found || rsp.exit_out !== want.exit_out ||
					    rsp.status !== want.status) begin
						if (n_err < 10) begin
							$display("mismatch %0d: expected found=%0b exit_out=%h status=%0b",
								n_rsp, want.found, want.exit_out, want.status);
							$display("  got found=%0b exit_out=%h status=%0b",
								rsp.found, rsp.exit_out, rsp.status);
						end
						n_err++;
					end
					if (want.status == STATUS_FULL)
						n_full++;
					if (want.found)
						n_hit++;
				end
			end
			if (req_valid && req_ready)
				expected_rsp.insert(expected_rsp.size(), predict_exit_table(req));
		end
		errors     <= n_err;
		pending    <= expected_rsp.size();
		responses  <= n_rsp;
		full_drops <= n_full;
		key_hits   <= n_hit;
	end

endmodule

@@ sim/position_keyed_exit_table_tb.sv @@
// ----------------------------------------------------------------------------
// position_keyed_exit_table_tb
// Stimulus and verdict for the position keyed exit table.
// A directed opening covers empty lookups and deletes, extreme keys and exit
// indexes, updates, the unused action code and slot reuse. Random bursts then
// alternate between filling and draining the table from a small key pool, so
// the table runs full and empties again, under three idling mixes, two long
// receiver stalls and pauses that drain every outstanding response.
// ----------------------------------------------------------------------------
module position_keyed_exit_table_tb;

	import pket_pkg::*;

	localparam int         TABLE_DEPTH     = 64;
	localparam int         POOL_SIZE       = 96;
	localparam int         ITEMS_PER_STAGE = 592;
	localparam int         BURST_LEN       = 105;
	localparam int         LONG_HOLD       = 400;
	localparam int         STALL_LIMIT     = 4000;
	localparam logic [1:0] ACT_UNUSED      = 2'd3;

	logic      clk;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	req_item_t req       = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	rsp_item_t rsp;

	int errors;
	int pending;
	int responses;
	int full_drops;
	int key_hits;

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	bit hold_rx     = 1'b0;
	int quiet_cycles;
	int n_sent [4]  = '{0, 0, 0, 0};

	logic [COORD_BITS-1:0] pool_x [POOL_SIZE];
	logic [COORD_BITS-1:0] pool_y [POOL_SIZE];

	position_keyed_exit_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	pket_exit_table_checker #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.errors    (errors),
		.pending   (pending),
		.responses (responses),
		.full_drops(full_drops),
		.key_hits  (key_hits)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("position_keyed_exit_table test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_rx) begin
				hold_rx = 1'b0;
				rsp_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	task automatic send_item(input logic [1:0] act, input logic [COORD_BITS-1:0] x,
		input logic [COORD_BITS-1:0] y, input logic [EXIT_BITS-1:0] ex);
		req_item_t it;
		it.action  = act;
		it.pos_x   = x;
		it.pos_y   = y;
		it.exit_in = ex;
		while ($urandom_range(99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req       <= it;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		n_sent[act]++;
	endtask

	task automatic send_random(input bit fill);
		int                    roll;
		int                    k;
		logic [1:0]            act;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		roll = $urandom_range(99);
		if (fill)
			act = roll < 70 ? ACT_ADD : roll < 80 ? ACT_DELETE :
				roll < 95 ? ACT_LOOKUP : ACT_UNUSED;
		else
			act = roll < 25 ? ACT_ADD : roll < 65 ? ACT_DELETE :
				roll < 95 ? ACT_LOOKUP : ACT_UNUSED;
		k = $urandom_range(POOL_SIZE - 1);
		x = pool_x[k];
		y = pool_y[k];
		if (act != ACT_ADD && $urandom_range(99) < 20) begin
			x = COORD_BITS'($urandom);
			y = COORD_BITS'($urandom);
		end
		send_item(act, x, y, EXIT_BITS'($urandom));
	endtask

	task automatic drain_responses();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		for (int i = 0; i < POOL_SIZE; i++) begin
			pool_x[i] = COORD_BITS'($urandom);
			pool_y[i] = COORD_BITS'($urandom);
		end
		pool_x[0] = '0;
		pool_y[0] = '0;
		pool_x[1] = '1;
		pool_y[1] = '1;
		pool_x[2] = '0;
		pool_y[2] = '1;
		pool_x[3] = '1;
		pool_y[3] = '0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		send_item(ACT_LOOKUP, '0, '0, '1);
		send_item(ACT_DELETE, '0, '0, '0);
		send_item(ACT_ADD, '0, '0, '0);
		send_item(ACT_ADD, '1, '1, '1);
		send_item(ACT_ADD, '1, '0, 16'h0001);
		send_item(ACT_ADD, '0, '1, 16'h8000);
		send_item(ACT_LOOKUP, '0, '0, '1);
		send_item(ACT_LOOKUP, '1, '1, '0);
		send_item(ACT_LOOKUP, '1, '0, '0);
		send_item(ACT_LOOKUP, '0, '1, '0);
		send_item(ACT_ADD, '0, '0, 16'hAAAA);
		send_item(ACT_LOOKUP, '0, '0, '0);
		send_item(ACT_UNUSED, '1, '1, '0);
		send_item(ACT_UNUSED, 12'h123, 12'h456, '1);
		send_item(ACT_LOOKUP, '1, '1, '0);
		send_item(ACT_DELETE, '1, '1, '1);
		send_item(ACT_LOOKUP, '1, '1, '0);
		send_item(ACT_DELETE, '1, '1, '0);
		send_item(ACT_ADD, '1, '1, 16'h5555);
		send_item(ACT_ADD, 12'h555, 12'hAAA, 16'h5555);
		send_item(ACT_ADD, 12'hAAA, 12'h555, 16'hAAAA);
		send_item(ACT_LOOKUP, '1, 12'h001, '0);
		send_item(ACT_LOOKUP, 12'hAAA, 12'h555, '0);
		send_item(ACT_LOOKUP, '1, '1, '0);
		drain_responses();

		for (int stage = 0; stage < 3; stage++) begin
			tx_idle_pct = stage == 0 ? 19 : stage == 1 ? 62 : 0;
			rx_idle_pct = stage == 0 ? 62 : stage == 1 ? 19 : 0;
			for (int n = 0; n < ITEMS_PER_STAGE; n++) begin
				if (n == ITEMS_PER_STAGE / 2 && stage != 1)
					hold_rx = 1'b1;
				send_random((n / BURST_LEN) % 2 == 0);
			end
			drain_responses();
		end

		repeat (TABLE_DEPTH + 8) @(posedge clk);
		$display("covered %0d adds, %0d deletes, %0d lookups, %0d unused codes",
			n_sent[ACT_ADD], n_sent[ACT_DELETE], n_sent[ACT_LOOKUP], n_sent[ACT_UNUSED]);
		$display("%0d responses checked, %0d key hits, %0d adds dropped on a full table",
			responses, key_hits, full_drops);
		if (errors == 0 && pending == 0) begin
			$display("position_keyed_exit_table test passed");
		end else begin
			$display("%0d errors, %0d responses missing", errors, pending);
			$display("position_keyed_exit_table test failed");
		end
		$finish;
	end

endmodule
